// ----- hw/rtl/dpcq_pkg.sv -----
`timescale 1ns / 1ps

package dpcq_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [2:0] CMD_ENQUEUE        = 3'd0;
  localparam logic [2:0] CMD_ENQUEUE_ABSENT = 3'd1;
  localparam logic [2:0] CMD_CANCEL         = 3'd2;
  localparam logic [2:0] CMD_CONTAINS       = 3'd3;
  localparam logic [2:0] CMD_FLUSH          = 3'd4;
  localparam logic [2:0] CMD_CLEAR_ALL      = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NULL = 2'd1;
  localparam logic [1:0] ST_DUP  = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_RUN    = 1'b1;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] key;
    logic [15:0] handler;
    logic [31:0] context_req;
    logic [15:0] prio;
    logic        single_run;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic        found;
    logic [4:0]  pending;
    logic [15:0] run_handler;
    logic [31:0] run_context;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] key;
    logic [15:0] handler;
    logic [31:0] user_word;
    logic [15:0] prio;
    logic        single;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_TAKE_UP,
    CELL_TAKE_DOWN
  } cell_op_t;

  typedef enum logic [2:0] {
    CH_IDLE,
    CH_WRITE,
    CH_REMOVE,
    CH_SORT,
    CH_ROTATE
  } chain_op_t;

  typedef struct packed {
    chain_op_t         op;
    logic [CNT_W-1:0]  count;
    logic              parity;
    logic [15:0]       key;
    entry_t            wr_entry;
  } chain_ctl_t;

  typedef struct packed {
    logic              hit;
    logic [CNT_W-1:0]  keep;
    entry_t            head;
  } chain_sts_t;

endpackage

// ----- hw/rtl/dpcq_cell.sv -----
`timescale 1ns / 1ps

module dpcq_cell (
  input  logic               clk,
  input  dpcq_pkg::cell_op_t op,
  input  dpcq_pkg::entry_t   load_entry,
  input  dpcq_pkg::entry_t   up_entry,
  input  dpcq_pkg::entry_t   down_entry,
  input  logic [15:0]        cmp_key,
  output dpcq_pkg::entry_t   entry,
  output logic               key_eq
);

  dpcq_pkg::entry_t entry_r;
  dpcq_pkg::entry_t entry_nxt;

  always_comb begin
    case (op)
      dpcq_pkg::CELL_HOLD:      entry_nxt = entry_r;
      dpcq_pkg::CELL_LOAD:      entry_nxt = load_entry;
      dpcq_pkg::CELL_TAKE_UP:   entry_nxt = up_entry;
      dpcq_pkg::CELL_TAKE_DOWN: entry_nxt = down_entry;
      default:                  entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry  = entry_r;
  assign key_eq = (entry_r.key == cmp_key);

endmodule

// ----- hw/rtl/dpcq_chain.sv -----
`timescale 1ns / 1ps

module dpcq_chain (
  input  logic                 clk,
  input  dpcq_pkg::chain_ctl_t ctl,
  output dpcq_pkg::chain_sts_t sts
);

  localparam int DEPTH = dpcq_pkg::DEPTH;
  localparam int CNT_W = dpcq_pkg::CNT_W;

  dpcq_pkg::entry_t cell_q [DEPTH];
  dpcq_pkg::entry_t load_bus;
  logic [DEPTH-1:0] key_eq_w;
  logic [DEPTH-1:0] occ;
  logic [DEPTH-1:0] eq;
  logic [DEPTH-1:0] single_v;
  logic [DEPTH-1:0] sw;
  logic [DEPTH-1:0] sw_below;
  logic [DEPTH-1:0] first_hit;
  logic [DEPTH-1:0] from_hit;
  logic [CNT_W-1:0] last_idx;

  assign last_idx = ctl.count - CNT_W'(1);

  // A rotation recirculates the head item into the last occupied slot.
  assign load_bus = (ctl.op == dpcq_pkg::CH_ROTATE) ? cell_q[0] : ctl.wr_entry;

  // Lowest matching slot, and every slot at or above it.
  assign first_hit = eq & ~(eq - DEPTH'(1));
  assign from_hit  = ~(first_hit - DEPTH'(1));

  assign sw_below = {sw[DEPTH-2:0], 1'b0};

  genvar j;
  generate
    for (j = 0; j < DEPTH; j++) begin : g_cell
      dpcq_pkg::cell_op_t op_c;
      dpcq_pkg::entry_t   up_c;
      dpcq_pkg::entry_t   down_c;

      assign occ[j]      = (CNT_W'(j) < ctl.count);
      assign eq[j]       = key_eq_w[j] & occ[j];
      assign single_v[j] = cell_q[j].single & occ[j];

      if (j < DEPTH - 1) begin : g_up
        assign up_c  = cell_q[j+1];
        // Odd-even transposition: swap only on a strict inversion, which keeps ties stable.
        assign sw[j] = (1'(j % 2) == ctl.parity) && occ[j+1]
                       && (cell_q[j].prio > cell_q[j+1].prio);
      end else begin : g_top
        assign up_c  = '0;
        assign sw[j] = 1'b0;
      end

      if (j > 0) begin : g_down
        assign down_c = cell_q[j-1];
      end else begin : g_bottom
        assign down_c = '0;
      end

      always_comb begin
        op_c = dpcq_pkg::CELL_HOLD;
        case (ctl.op)
          dpcq_pkg::CH_WRITE: begin
            if (CNT_W'(j) == ctl.count) op_c = dpcq_pkg::CELL_LOAD;
          end
          dpcq_pkg::CH_REMOVE: begin
            if (from_hit[j]) op_c = dpcq_pkg::CELL_TAKE_UP;
          end
          dpcq_pkg::CH_SORT: begin
            if (sw[j]) op_c = dpcq_pkg::CELL_TAKE_UP;
            else if (sw_below[j]) op_c = dpcq_pkg::CELL_TAKE_DOWN;
          end
          dpcq_pkg::CH_ROTATE: begin
            if (CNT_W'(j) < last_idx) op_c = dpcq_pkg::CELL_TAKE_UP;
            else if (CNT_W'(j) == last_idx) op_c = dpcq_pkg::CELL_LOAD;
          end
          default: op_c = dpcq_pkg::CELL_HOLD;
        endcase
      end

      dpcq_cell u_cell (
        .clk        (clk),
        .op         (op_c),
        .load_entry (load_bus),
        .up_entry   (up_c),
        .down_entry (down_c),
        .cmp_key    (ctl.key),
        .entry      (cell_q[j]),
        .key_eq     (key_eq_w[j])
      );
    end
  endgenerate

  assign sts.hit  = |eq;
  assign sts.keep = ctl.count - CNT_W'($countones(single_v));
  assign sts.head = cell_q[0];

endmodule

// ----- hw/rtl/deferred_priority_command_queue.sv -----
`timescale 1ns / 1ps

// Channel  Direction  Payload                    Handshake
// in_      input      dpcq_pkg::in_item_t        in_valid / in_ready
// out_     output     dpcq_pkg::out_item_t       out_valid / out_ready
//
// Enqueue, enqueue-if-absent, contains, clear-all: the decode state, then the report state
// registers the result. Cancel: the remove state takes out one matching entry at a time;
// the search ends on the first cycle that finds no match. Flush of n entries: decode, then n
// passes of odd-even sorting in the cell row, then the emit state sends one item per entry.
// A new item is taken only once the previous one is done.
// Reset (rst_n low, synchronous) empties the table; entry contents are not cleared.
// A stalled out_ready holds the result in the output register; the block keeps working
// until it needs that register again.

module deferred_priority_command_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dpcq_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output dpcq_pkg::out_item_t out_item
);

  localparam int DEPTH = dpcq_pkg::DEPTH;
  localparam int CNT_W = dpcq_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_REMOVE,
    S_SORT,
    S_EMIT,
    S_REPORT
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  dpcq_pkg::in_item_t   req_r, req_nxt;
  logic [1:0]           status_r, status_nxt;
  logic                 found_r, found_nxt;
  logic [CNT_W-1:0]     pass_r, pass_nxt;
  logic [CNT_W-1:0]     emit_r, emit_nxt;
  logic [CNT_W-1:0]     num_r, num_nxt;
  logic [CNT_W-1:0]     keep_r, keep_nxt;
  dpcq_pkg::out_item_t  out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  dpcq_pkg::chain_ctl_t ctl;
  dpcq_pkg::chain_sts_t sts;

  logic slot_free;
  logic full;
  logic null_req;

  assign slot_free = !out_valid_r || out_ready;
  assign full      = (count_r == CNT_W'(DEPTH));
  assign null_req  = (req_r.key == 16'd0) || (req_r.handler == 16'd0);
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    req_nxt       = req_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    pass_nxt      = pass_r;
    emit_nxt      = emit_r;
    num_nxt       = num_r;
    keep_nxt      = keep_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    ctl.op                 = dpcq_pkg::CH_IDLE;
    ctl.count              = count_r;
    ctl.parity             = pass_r[0];
    ctl.key                = req_r.key;
    ctl.wr_entry.key       = req_r.key;
    ctl.wr_entry.handler   = req_r.handler;
    ctl.wr_entry.user_word = req_r.context_req;
    ctl.wr_entry.prio      = req_r.prio;
    // Enqueue-if-absent always stores a one-shot entry.
    ctl.wr_entry.single    = (req_r.command == dpcq_pkg::CMD_ENQUEUE_ABSENT)
                             ? 1'b1 : req_r.single_run;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_item;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        status_nxt = dpcq_pkg::ST_OK;
        found_nxt  = 1'b0;
        state_nxt  = S_REPORT;
        case (req_r.command)
          dpcq_pkg::CMD_ENQUEUE: begin
            if (null_req) status_nxt = dpcq_pkg::ST_NULL;
            else if (full) status_nxt = dpcq_pkg::ST_FULL;
            else begin
              ctl.op    = dpcq_pkg::CH_WRITE;
              count_nxt = count_r + CNT_W'(1);
            end
          end
          dpcq_pkg::CMD_ENQUEUE_ABSENT: begin
            if (null_req) status_nxt = dpcq_pkg::ST_NULL;
            else if (sts.hit) status_nxt = dpcq_pkg::ST_DUP;
            else if (full) status_nxt = dpcq_pkg::ST_FULL;
            else begin
              ctl.op    = dpcq_pkg::CH_WRITE;
              count_nxt = count_r + CNT_W'(1);
            end
          end
          dpcq_pkg::CMD_CANCEL: begin
            if (req_r.key == 16'd0) status_nxt = dpcq_pkg::ST_NULL;
            else state_nxt = S_REMOVE;
          end
          dpcq_pkg::CMD_CONTAINS: begin
            if (req_r.key == 16'd0) status_nxt = dpcq_pkg::ST_NULL;
            else found_nxt = sts.hit;
          end
          dpcq_pkg::CMD_FLUSH: begin
            if (count_r != '0) begin
              num_nxt   = count_r;
              keep_nxt  = sts.keep;
              pass_nxt  = '0;
              state_nxt = S_SORT;
            end
          end
          dpcq_pkg::CMD_CLEAR_ALL: begin
            count_nxt = '0;
          end
          default: begin
            status_nxt = dpcq_pkg::ST_OK;
          end
        endcase
      end

      S_REMOVE: begin
        ctl.op = dpcq_pkg::CH_REMOVE;
        if (sts.hit) count_nxt = count_r - CNT_W'(1);
        else state_nxt = S_REPORT;
      end

      S_SORT: begin
        ctl.op   = dpcq_pkg::CH_SORT;
        pass_nxt = pass_r + CNT_W'(1);
        if (pass_r == num_r - CNT_W'(1)) begin
          emit_nxt  = '0;
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        if (slot_free) begin
          // Pop the head; a repeating entry goes back in at the tail, a one-shot one is dropped.
          ctl.op              = dpcq_pkg::CH_ROTATE;
          out_nxt.kind        = dpcq_pkg::KIND_RUN;
          out_nxt.status      = dpcq_pkg::ST_OK;
          out_nxt.found       = 1'b0;
          out_nxt.pending     = 5'(keep_r);
          out_nxt.run_handler = sts.head.handler;
          out_nxt.run_context = sts.head.user_word;
          out_nxt.last        = (emit_r == num_r - CNT_W'(1));
          out_valid_nxt       = 1'b1;
          if (sts.head.single) count_nxt = count_r - CNT_W'(1);
          emit_nxt = emit_r + CNT_W'(1);
          if (emit_r == num_r - CNT_W'(1)) state_nxt = S_IDLE;
        end
      end

      S_REPORT: begin
        if (slot_free) begin
          out_nxt.kind        = dpcq_pkg::KIND_STATUS;
          out_nxt.status      = status_r;
          out_nxt.found       = found_r;
          out_nxt.pending     = 5'(count_r);
          out_nxt.run_handler = '0;
          out_nxt.run_context = '0;
          out_nxt.last        = 1'b1;
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      req_r       <= req_nxt;
      status_r    <= status_nxt;
      found_r     <= found_nxt;
      pass_r      <= pass_nxt;
      emit_r      <= emit_nxt;
      num_r       <= num_nxt;
      keep_r      <= keep_nxt;
      out_r       <= out_nxt;
    end
  end

  dpcq_chain u_chain (
    .clk (clk),
    .ctl (ctl),
    .sts (sts)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("table count exceeds depth");

  a_emit_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (count_r >= keep_r))
    else $error("flush dropped more entries than it has one-shot entries");

  a_flush_end: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r) == S_EMIT && state_r == S_IDLE) |-> (count_r == keep_r))
    else $error("count after flush differs from the announced pending count");

endmodule

// ----- bench/deferred_priority_command_queue_tb.sv -----
`timescale 1ns / 1ps

module deferred_priority_command_queue_tb;

  localparam logic [2:0] CMD_UNUSED_A = 3'd6;
  localparam logic [2:0] CMD_UNUSED_B = 3'd7;
  localparam int RANDOM_ITEMS = 125;
  localparam int IDLE_LIMIT = 4000;
  localparam int LONG_HOLD = 400;

  typedef struct {
    dpcq_pkg::in_item_t item;
    int                 gap;
    bit                 drain;
  } offer_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  dpcq_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  dpcq_pkg::out_item_t out_item;

  offer_t              backlog[$];
  dpcq_pkg::out_item_t due[$];
  dpcq_pkg::entry_t    held[$];
  logic                in_acc = 1'b0;
  logic                out_acc = 1'b0;
  int                  n_accepted = 0;
  int                  mismatches = 0;
  int                  idle_cycles = 0;

  deferred_priority_command_queue dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit key_held(logic [15:0] key);
    foreach (held[i]) begin
      if (held[i].key == key) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Updates the table copy and queues the results that one command produces.
  task automatic apply_command(input dpcq_pkg::in_item_t c);
    dpcq_pkg::entry_t    e;
    dpcq_pkg::entry_t    ordered[$];
    dpcq_pkg::entry_t    kept[$];
    dpcq_pkg::out_item_t r;
    int                  j;
    logic [1:0]          st;
    logic                fnd;
    st = dpcq_pkg::ST_OK;
    fnd = 1'b0;
    case (c.command)
      dpcq_pkg::CMD_ENQUEUE, dpcq_pkg::CMD_ENQUEUE_ABSENT: begin
        if (c.key == 16'd0 || c.handler == 16'd0) begin
          st = dpcq_pkg::ST_NULL;
        end else if (c.command == dpcq_pkg::CMD_ENQUEUE_ABSENT && key_held(c.key)) begin
          st = dpcq_pkg::ST_DUP;
        end else if (held.size() >= dpcq_pkg::DEPTH) begin
          st = dpcq_pkg::ST_FULL;
        end else begin
          e.key = c.key;
          e.handler = c.handler;
          e.user_word = c.context_req;
          e.prio = c.prio;
          e.single = (c.command == dpcq_pkg::CMD_ENQUEUE_ABSENT) ? 1'b1 : c.single_run;
          held.push_back(e);
        end
      end
      dpcq_pkg::CMD_CANCEL: begin
        if (c.key == 16'd0) begin
          st = dpcq_pkg::ST_NULL;
        end else begin
          foreach (held[i]) begin
            if (held[i].key != c.key) kept.push_back(held[i]);
          end
          held = kept;
        end
      end
      dpcq_pkg::CMD_CONTAINS: begin
        if (c.key == 16'd0) st = dpcq_pkg::ST_NULL;
        else fnd = key_held(c.key);
      end
      dpcq_pkg::CMD_CLEAR_ALL: begin
        held = {};
      end
      default: begin
      end
    endcase
    if (c.command == dpcq_pkg::CMD_FLUSH && held.size() != 0) begin
      // Insert after every entry of equal priority so that ties keep their order.
      foreach (held[i]) begin
        j = 0;
        while (j < ordered.size() && ordered[j].prio <= held[i].prio) j++;
        ordered.insert(j, held[i]);
      end
      held = {};
      foreach (ordered[i]) begin
        if (!ordered[i].single) held.push_back(ordered[i]);
      end
      foreach (ordered[i]) begin
        r = '0;
        r.kind = dpcq_pkg::KIND_RUN;
        r.status = dpcq_pkg::ST_OK;
        r.pending = 5'(held.size());
        r.run_handler = ordered[i].handler;
        r.run_context = ordered[i].user_word;
        r.last = (i == ordered.size() - 1);
        due.push_back(r);
      end
    end else begin
      r = '0;
      r.kind = dpcq_pkg::KIND_STATUS;
      r.status = st;
      r.found = fnd;
      r.pending = 5'(held.size());
      r.last = 1'b1;
      due.push_back(r);
    end
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : sample
    dpcq_pkg::out_item_t want;
    in_acc <= rst_n && in_valid && in_ready;
    out_acc <= rst_n && out_valid && out_ready;
    if (rst_n && out_valid && out_ready) begin
      if (due.size() == 0) begin
        $error("result item arrived with nothing expected");
        mismatches++;
      end else begin
        want = due.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_item.kind));
        check_field("status", 32'(want.status), 32'(out_item.status));
        check_field("found", 32'(want.found), 32'(out_item.found));
        check_field("pending", 32'(want.pending), 32'(out_item.pending));
        check_field("run_handler", 32'(want.run_handler), 32'(out_item.run_handler));
        check_field("run_context", want.run_context, out_item.run_context);
        check_field("last", 32'(want.last), 32'(out_item.last));
      end
    end
    if (rst_n && in_valid && in_ready) begin
      apply_command(in_item);
      n_accepted++;
    end
  end

  // Sender: each item waits out its own gap; a drain item waits for all results.
  always @(negedge clk) begin : sender
    int  tx_gap;
    bit  gap_spent;
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap = 0;
      gap_spent = 1'b0;
    end else if (!in_valid || in_acc) begin
      if (tx_gap != 0) begin
        in_valid <= 1'b0;
        tx_gap--;
      end else if (backlog.size() == 0) begin
        in_valid <= 1'b0;
      end else if (!gap_spent && backlog[0].gap != 0) begin
        in_valid <= 1'b0;
        tx_gap = backlog[0].gap - 1;
        gap_spent = 1'b1;
      end else if (backlog[0].drain && due.size() != 0) begin
        in_valid <= 1'b0;
      end else begin
        in_item <= backlog[0].item;
        in_valid <= 1'b1;
        void'(backlog.pop_front());
        gap_spent = 1'b0;
      end
    end
  end

  // Receiver: random stalls per item, calm stretches, and one long hold-off.
  always @(negedge clk) begin : receiver
    int rx_hold;
    int rx_taken;
    bit rx_calm;
    int w;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_hold = 0;
      rx_taken = 0;
      rx_calm = 1'b0;
    end else if (rx_hold != 0) begin
      out_ready <= 1'b0;
      rx_hold--;
    end else if (out_acc) begin
      rx_taken++;
      if (rx_taken % 24 == 0) rx_calm = !rx_calm;
      w = rx_calm ? 0 : $urandom_range(0, 12);
      if (rx_taken == 40) w = LONG_HOLD;
      if (w == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        rx_hold = w - 1;
      end
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic dpcq_pkg::in_item_t make_item(logic [2:0] cmd, logic [15:0] key,
                                                   logic [15:0] hnd, logic [31:0] ctx,
                                                   logic [15:0] prio, logic single);
    dpcq_pkg::in_item_t c;
    c.command = cmd;
    c.key = key;
    c.handler = hnd;
    c.context_req = ctx;
    c.prio = prio;
    c.single_run = single;
    return c;
  endfunction

  function automatic logic [15:0] pick_key(int spread);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'd0;
    if (r < 4) return 16'($urandom);
    return 16'($urandom_range(1, spread));
  endfunction

  function automatic logic [15:0] pick_handler();
    if ($urandom_range(0, 19) == 0) return 16'd0;
    return 16'($urandom_range(1, 65535));
  endfunction

  // Small priorities collide often, which exercises the ordering of ties.
  function automatic logic [15:0] pick_prio();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd2;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic dpcq_pkg::in_item_t random_command(int spread);
    dpcq_pkg::in_item_t c;
    int                 r;
    r = $urandom_range(0, 99);
    c = make_item(dpcq_pkg::CMD_ENQUEUE, pick_key(spread), pick_handler(), $urandom,
                  pick_prio(), 1'($urandom));
    if (r >= 95) c.command = $urandom_range(0, 1) ? CMD_UNUSED_A : CMD_UNUSED_B;
    else if (r >= 91) c.command = dpcq_pkg::CMD_CLEAR_ALL;
    else if (r >= 80) c.command = dpcq_pkg::CMD_FLUSH;
    else if (r >= 67) c.command = dpcq_pkg::CMD_CONTAINS;
    else if (r >= 55) c.command = dpcq_pkg::CMD_CANCEL;
    else if (r >= 35) c.command = dpcq_pkg::CMD_ENQUEUE_ABSENT;
    return c;
  endfunction

  task automatic offer(input dpcq_pkg::in_item_t c, input bit calm, input bit drain);
    offer_t o;
    o.item = c;
    o.gap = calm ? 0 : $urandom_range(0, 12);
    o.drain = drain;
    backlog.push_back(o);
  endtask

  initial begin : stimulus
    int  n_total;
    int  n_random;
    int  len;
    bit  calm;
    bit  drain;
    n_random = 0;

    offer(make_item(dpcq_pkg::CMD_FLUSH, 16'($urandom), 16'($urandom), $urandom,
                    16'($urandom), 1'b1), 1'b0, 1'b0);
    offer(make_item(dpcq_pkg::CMD_ENQUEUE, 16'd0, 16'd5, 32'd1, 16'd1, 1'b0), 1'b0, 1'b0);
    offer(make_item(dpcq_pkg::CMD_ENQUEUE, 16'd5, 16'd0, 32'd1, 16'd1, 1'b0), 1'b0, 1'b0);
    offer(make_item(dpcq_pkg::CMD_ENQUEUE_ABSENT, 16'd0, 16'd0, 32'd2, 16'd2, 1'b0),
          1'b0, 1'b0);
    offer(make_item(dpcq_pkg::CMD_CANCEL, 16'd0, 16'd3, 32'd0, 16'd0, 1'b0), 1'b0, 1'b0);
    offer(make_item(dpcq_pkg::CMD_CONTAINS, 16'd0, 16'd3, 32'd0, 16'd0, 1'b0), 1'b0, 1'b0);
    offer(make_item(dpcq_pkg::CMD_ENQUEUE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF,
                    1'b0), 1'b0, 1'b0);
    offer(make_item(dpcq_pkg::CMD_ENQUEUE, 16'd1, 16'd1, 32'd0, 16'd0, 1'b1), 1'b1, 1'b0);
    offer(make_item(dpcq_pkg::CMD_ENQUEUE, 16'd2, 16'd2, 32'h1234_5678, 16'd7, 1'b0),
          1'b1, 1'b0);
    offer(make_item(dpcq_pkg::CMD_ENQUEUE, 16'd3, 16'd3, 32'h8765_4321, 16'd7, 1'b1),
          1'b1, 1'b0);
    offer(make_item(dpcq_pkg::CMD_ENQUEUE_ABSENT, 16'd1, 16'd9, 32'd9, 16'd9, 1'b0),
          1'b0, 1'b0);
    // Enqueue-if-absent stores a one-shot entry even when single_run is low.
    offer(make_item(dpcq_pkg::CMD_ENQUEUE_ABSENT, 16'd4, 16'd4, 32'hA5A5_5A5A, 16'd7, 1'b0),
          1'b0, 1'b0);
    offer(make_item(dpcq_pkg::CMD_CONTAINS, 16'd2, 16'd0, 32'd0, 16'd0, 1'b0), 1'b0, 1'b0);
    offer(make_item(dpcq_pkg::CMD_CONTAINS, 16'd9, 16'd0, 32'd0, 16'd0, 1'b0), 1'b0, 1'b0);
    offer(make_item(CMD_UNUSED_A, 16'd2, 16'd2, 32'd0, 16'd0, 1'b0), 1'b0, 1'b0);
    offer(make_item(CMD_UNUSED_B, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1),
          1'b0, 1'b0);
    offer(make_item(dpcq_pkg::CMD_FLUSH, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1),
          1'b0, 1'b0);
    offer(make_item(dpcq_pkg::CMD_FLUSH, 16'd0, 16'd0, 32'd0, 16'd0, 1'b0), 1'b1, 1'b0);
    offer(make_item(dpcq_pkg::CMD_CANCEL, 16'hFFFF, 16'd0, 32'd0, 16'd0, 1'b0), 1'b0, 1'b0);
    offer(make_item(dpcq_pkg::CMD_ENQUEUE, 16'd2, 16'd6, 32'd6, 16'd0, 1'b0), 1'b0, 1'b0);
    offer(make_item(dpcq_pkg::CMD_CANCEL, 16'd2, 16'd0, 32'd0, 16'd0, 1'b0), 1'b0, 1'b0);
    offer(make_item(dpcq_pkg::CMD_CLEAR_ALL, 16'($urandom), 16'($urandom), $urandom,
                    16'($urandom), 1'b1), 1'b0, 1'b0);
    offer(make_item(dpcq_pkg::CMD_FLUSH, 16'd0, 16'd0, 32'd0, 16'd0, 1'b0), 1'b0, 1'b0);
    offer(make_item(dpcq_pkg::CMD_CONTAINS, 16'd2, 16'd0, 32'd0, 16'd0, 1'b0), 1'b0, 1'b1);

    // Random part: fill-and-flush runs that can reach a full table, and mixed runs.
    while (n_random < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      drain = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 2) == 0) begin
          offer(make_item(dpcq_pkg::CMD_CLEAR_ALL, 16'($urandom), 16'($urandom), $urandom,
                          16'($urandom), 1'($urandom)), calm, drain);
          drain = 1'b0;
          n_random++;
        end
        len = $urandom_range(14, 19);
        repeat (len) begin
          offer(make_item($urandom_range(0, 3) == 0 ? dpcq_pkg::CMD_ENQUEUE_ABSENT
                                                    : dpcq_pkg::CMD_ENQUEUE,
                          pick_key(24), pick_handler(), $urandom, pick_prio(),
                          1'($urandom)), calm, drain);
          drain = 1'b0;
        end
        offer(make_item(dpcq_pkg::CMD_FLUSH, 16'($urandom), 16'($urandom), $urandom,
                        16'($urandom), 1'($urandom)), calm, 1'b0);
        n_random += len + 1;
      end else begin
        len = $urandom_range(4, 10);
        repeat (len) begin
          offer(random_command(6), calm, drain);
          drain = 1'b0;
        end
        n_random += len;
      end
    end
    n_total = backlog.size();

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (n_accepted != n_total || due.size() != 0);
    repeat (60) @(negedge clk);
    if (mismatches == 0 && due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
